### hw/rtl/bounded_deque_front_back_unit_assert.svh
// assertion macros for the bounded deque block
`ifndef BOUNDED_DEQUE_FRONT_BACK_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_FRONT_BACK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BDQ_ASSERT_NORST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BDQ_ASSERT(label, prop, msg)
`define BDQ_ASSERT_NORST(label, prop, msg)
`endif

`endif

### hw/rtl/bdq_pkg.sv
// types and constants shared by the bounded deque modules
package bdq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 7;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_LIST       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t   func;
        data_t data_in;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        data_t             value_out;
        logic [OCC_W-1:0]  occupancy;
        logic              last;
    } out_item_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHR,
        CELL_SHL,
        CELL_ROT,
        CELL_LOAD_BACK
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       at_tail;
        logic       at_back;
    } cell_ctl_t;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

endpackage

### hw/rtl/bdq_cell.sv
// one storage cell of the deque chain
module bdq_cell import bdq_pkg::*; (
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  data_t     left_in,
    input  data_t     right_in,
    input  data_t     head_in,
    input  data_t     data_in,
    output data_t     q
);

    data_t entry_reg;
    data_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        case (ctl.mode)
            CELL_HOLD:      entry_next = entry_reg;
            CELL_SHR:       entry_next = left_in;
            CELL_SHL:       entry_next = right_in;
            // tail of the held run wraps around to the head
            CELL_ROT:       entry_next = ctl.at_tail ? head_in : right_in;
            CELL_LOAD_BACK: entry_next = ctl.at_back ? data_in : entry_reg;
            default:        entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

### hw/rtl/bdq_chain.sv
// row of deque cells, front entry in cell zero
module bdq_chain import bdq_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  cell_mode_t       mode,
    input  logic [CNT_W-1:0] count,
    input  data_t            data_in,
    output data_t            head_out
);

    data_t cell_q [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            cell_ctl_t ctl;
            data_t     left_d;
            data_t     right_d;

            assign ctl.mode    = mode;
            assign ctl.at_tail = (count == CNT_W'(i + 1));
            assign ctl.at_back = (count == CNT_W'(i));

            if (i == 0) begin : g_first
                assign left_d = data_in;
            end else begin : g_mid_l
                assign left_d = cell_q[i-1];
            end

            if (i == DEPTH - 1) begin : g_last
                assign right_d = cell_q[i];
            end else begin : g_mid_r
                assign right_d = cell_q[i+1];
            end

            bdq_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .left_in  (left_d),
                .right_in (right_d),
                .head_in  (cell_q[0]),
                .data_in  (data_in),
                .q        (cell_q[i])
            );
        end
    endgenerate

    assign head_out = cell_q[0];

endmodule

### hw/rtl/bounded_deque_front_back_unit.sv
// bounded deque of signed 32-bit values built as a chain of shifting cells
//
// input channel s_valid/s_ready/s_payload carries an operation and a value;
// result channel m_valid/m_ready/m_payload carries status, value, occupancy
// and a last flag. every transaction on the input gives one or more results.
// push front, push back and pop front give one result each: the result sits in
// the output register the cycle after the input transaction, and a new input
// is taken every cycle as long as the receiver keeps up.
// list gives count results, or one when empty: the input transaction enters
// the list state, then each of the count steps puts one entry in the output
// register. the cell chain rotates by one place per result so cell zero always
// holds the entry to emit, and after count steps the order is back where it was.
// no input is taken while a list is in progress.
// when the receiver stalls, the output register holds its result and the
// block takes no new input and advances no list step until it drains.
// reset (aresetn low, synchronous) empties the deque and drops any pending
// result; cell contents are not cleared and are never read before written.
module bounded_deque_front_back_unit import bdq_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    `include "bounded_deque_front_back_unit_assert.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] list_idx_reg, list_idx_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;

    cell_mode_t mode;
    data_t      head;
    logic       out_free;
    logic       in_fire;
    logic       list_step;
    logic       list_last;
    logic       full;
    logic       empty;

    bdq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_chain (
        .aclk     (aclk),
        .mode     (mode),
        .count    (count_reg),
        .data_in  (s_payload.data_in),
        .head_out (head)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && out_free;
    assign in_fire   = s_valid && s_ready;
    assign list_step = (state_reg == S_LIST) && out_free;
    assign list_last = (CNT_W'(list_idx_reg) + CNT_W'(1)) == count_reg;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire && s_payload.func == OP_LIST && !empty) begin
                    state_next = S_LIST;
                end
            end
            S_LIST: begin
                if (list_step && list_last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // chain control, count and result register
    always_comb begin
        mode          = CELL_HOLD;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_item_next   = m_item_reg;

        if (in_fire) begin
            m_valid_next          = 1'b1;
            m_item_next.status    = ST_OK;
            m_item_next.value_out = '0;
            m_item_next.occupancy = OCC_W'(count_reg);
            m_item_next.last      = 1'b1;
            case (s_payload.func)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (full) begin
                        m_item_next.status = ST_FULL;
                    end else begin
                        mode = (s_payload.func == OP_PUSH_FRONT) ? CELL_SHR : CELL_LOAD_BACK;
                        count_next = count_reg + CNT_W'(1);
                        m_item_next.occupancy = OCC_W'(count_next);
                    end
                end
                OP_POP_FRONT: begin
                    if (empty) begin
                        m_item_next.status = ST_EMPTY;
                    end else begin
                        mode = CELL_SHL;
                        count_next = count_reg - CNT_W'(1);
                        m_item_next.value_out = head;
                        m_item_next.occupancy = OCC_W'(count_next);
                    end
                end
                OP_LIST: begin
                    if (empty) begin
                        m_item_next.status = ST_EMPTY;
                    end else begin
                        // entries come out in the list state
                        m_valid_next  = m_valid_reg && !m_ready;
                        m_item_next   = m_item_reg;
                        list_idx_next = '0;
                    end
                end
                default: begin
                    m_item_next.status = ST_EMPTY;
                end
            endcase
        end else if (list_step) begin
            mode                  = CELL_ROT;
            m_valid_next          = 1'b1;
            m_item_next.status    = ST_OK;
            m_item_next.value_out = head;
            m_item_next.occupancy = OCC_W'(count_reg);
            m_item_next.last      = list_last;
            list_idx_next         = list_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_item_reg;

    `BDQ_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `BDQ_ASSERT(a_no_input_in_list, state_reg == S_LIST |-> !s_ready, "input taken during list")
    `BDQ_ASSERT(a_list_idx_range,
                state_reg == S_LIST |-> CNT_W'(list_idx_reg) < count_reg,
                "list index past held entries")
    `BDQ_ASSERT(a_push_grows,
                in_fire && s_payload.func == OP_PUSH_BACK && !full
                |=> count_reg == $past(count_reg) + CNT_W'(1),
                "push back did not add an entry")
    `BDQ_ASSERT_NORST(a_reset_clears,
                      !aresetn |=> !m_valid && state_reg == S_IDLE,
                      "reset left a result or list pending")

endmodule
